// ----- src/sliding_window_min_max_top_assert.svh -----
// ----------------------------------------------------------------------------
// sliding window min/max assertion macros
// Concurrent assertion wrappers shared by the block's RTL files. Defining
// NO_ASSERTIONS turns every use into nothing.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MIN_MAX_TOP_ASSERT_SVH
`define SLIDING_WINDOW_MIN_MAX_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// expression must hold at every clock edge out of reset
`define SWMM_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("swmm assertion failed");

// consequent must hold in the same cycle as the antecedent
`define SWMM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swmm assertion failed");

`else

`define SWMM_ASSERT(label, clk, rst_n, expr)
`define SWMM_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/swmm_pkg.sv -----
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared constants and types of the sliding window min/max block.
// ----------------------------------------------------------------------------
package swmm_pkg;

    // number of sample positions held in the cell chain
    localparam int WINDOW_MAX = 32;

    // field widths
    localparam int SMP_W = 16;
    localparam int CNT_W = 16;
    localparam int CFG_W = 6;

    // 150.0 in 8.8 fixed point, first invalid reading
    localparam logic [SMP_W-1:0] LIMIT_150 = SMP_W'(38400);

    // saturation value of the invalid counter
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // reset value of the window size register
    localparam logic [CFG_W-1:0] WIN_SIZE_RST = CFG_W'(1);

    // running min/max travelling along the chain with its token
    typedef struct packed {
        logic             tok;
        logic [SMP_W-1:0] mn;
        logic [SMP_W-1:0] mx;
        logic             empty;
    } t_acc;

endpackage

// ----- src/swmm_cell.sv -----
// ----------------------------------------------------------------------------
// swmm_cell
// One window position: holds a sample and its valid flag, shifts them on to
// the next older position, and folds them into the passing min/max token.
// ----------------------------------------------------------------------------
module swmm_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_shift,
    input  logic [swmm_pkg::SMP_W-1:0] i_smp,
    input  logic                      i_vld,
    input  logic                      i_in_win,
    input  swmm_pkg::t_acc            i_acc,
    output logic [swmm_pkg::SMP_W-1:0] o_smp,
    output logic                      o_vld,
    output swmm_pkg::t_acc            o_acc
);

    logic [swmm_pkg::SMP_W-1:0] r_smp;
    logic                       r_vld;
    swmm_pkg::t_acc             r_acc;
    swmm_pkg::t_acc             n_acc;
    logic                       w_use;

    // this position takes part when it lies in the window and holds a valid sample
    assign w_use = i_in_win && r_vld;

    // fold own sample into the running min/max
    always_comb begin
        n_acc = i_acc;
        if (w_use) begin
            if (r_smp < i_acc.mn) begin
                n_acc.mn = r_smp;
            end
            if (r_smp > i_acc.mx) begin
                n_acc.mx = r_smp;
            end
            n_acc.empty = 1'b0;
        end
    end

    // sample storage, shifted one position older per accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_shift) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_smp <= i_smp;
        end
    end

    // token stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc.tok <= 1'b0;
        end else begin
            r_acc.tok <= i_acc.tok;
        end
        r_acc.mn    <= n_acc.mn;
        r_acc.mx    <= n_acc.mx;
        r_acc.empty <= n_acc.empty;
    end

    assign o_smp = r_smp;
    assign o_vld = r_vld;
    assign o_acc = r_acc;

endmodule

// ----- src/sliding_window_min_max_top.sv -----
// ----------------------------------------------------------------------------
// sliding_window_min_max_top
// Sliding window minimum and maximum of an 8.8 fixed point voltage stream.
// ----------------------------------------------------------------------------
// Each accepted sample is shifted into a chain of 32 cells, newest first, and
// one result follows per sample: the min and max of the valid samples (below
// 150.0) among the last window_size positions, with 150.0 and 0 reported when
// none is valid. A token carrying the running min/max then walks the chain
// one cell per clock (injection register, 32 cell stages, pending stage,
// output register); the input stalls until the output register is loaded.
// The output register holds a finished result while the next sample is
// accepted and scanned; window_size 0 acts as 1. The user must write it
// through the configuration channel while the block is idle, unenforced.
// ----------------------------------------------------------------------------
`include "sliding_window_min_max_top_assert.svh"

module sliding_window_min_max_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // sample input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [swmm_pkg::SMP_W-1:0]  i_sample,
    // result output channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [swmm_pkg::CNT_W-1:0]  o_sample_index,
    output logic [swmm_pkg::SMP_W-1:0]  o_sample_echo,
    output logic                        o_sample_valid,
    output logic [swmm_pkg::SMP_W-1:0]  o_window_min,
    output logic [swmm_pkg::SMP_W-1:0]  o_window_max,
    output logic                        o_window_empty,
    output logic [swmm_pkg::CNT_W-1:0]  o_invalid_total,
    // window size configuration channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [swmm_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam int WMAX = swmm_pkg::WINDOW_MAX;

    logic [swmm_pkg::CFG_W-1:0] r_win_size;
    logic                       r_busy;
    logic                       r_inject;
    logic                       r_pend_full;
    swmm_pkg::t_acc             r_pend_acc;

    logic [swmm_pkg::CNT_W-1:0] r_smp_cnt;
    logic [swmm_pkg::CNT_W-1:0] r_inv_cnt;
    logic [swmm_pkg::CNT_W-1:0] n_smp_cnt;
    logic [swmm_pkg::CNT_W-1:0] n_inv_cnt;
    logic [swmm_pkg::SMP_W-1:0] r_cur_smp;
    logic                       r_cur_vld;

    logic                       w_accept;
    logic                       w_in_vld;
    logic                       w_exit;
    logic                       w_load_out;

    logic [swmm_pkg::SMP_W-1:0] w_smp [0:WMAX];
    logic                       w_vld [0:WMAX];
    swmm_pkg::t_acc             w_acc [0:WMAX];
    logic [WMAX-1:0]            w_in_win;
    logic [WMAX:0]              w_toks;

    // handshakes
    assign o_in_stall  = r_busy;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && !r_busy;
    assign w_in_vld    = i_sample < swmm_pkg::LIMIT_150;
    assign w_exit      = w_acc[WMAX].tok;
    assign w_load_out  = r_pend_full && (!o_out_valid || !i_out_stall);

    // window size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_size <= swmm_pkg::WIN_SIZE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_win_size <= i_cfg_data;
        end
    end

    // running counters, index wraps and invalid count saturates
    always_comb begin
        n_smp_cnt = r_smp_cnt + swmm_pkg::CNT_W'(1);
        n_inv_cnt = r_inv_cnt;
        if (!w_in_vld && (r_inv_cnt != swmm_pkg::CNT_MAX)) begin
            n_inv_cnt = r_inv_cnt + swmm_pkg::CNT_W'(1);
        end
    end

    // control: one transaction in flight through the chain at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_inject    <= 1'b0;
            r_pend_full <= 1'b0;
            r_smp_cnt   <= '0;
            r_inv_cnt   <= '0;
        end else begin
            r_inject <= w_accept;
            if (w_accept) begin
                r_busy    <= 1'b1;
                r_smp_cnt <= n_smp_cnt;
                r_inv_cnt <= n_inv_cnt;
            end else if (w_load_out) begin
                r_busy <= 1'b0;
            end
            if (w_exit) begin
                r_pend_full <= 1'b1;
            end else if (w_load_out) begin
                r_pend_full <= 1'b0;
            end
        end
    end

    // echo of the current transaction and the finished scan
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cur_smp <= i_sample;
            r_cur_vld <= w_in_vld;
        end
        if (w_exit) begin
            r_pend_acc <= w_acc[WMAX];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_load_out) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            o_sample_index  <= r_smp_cnt;
            o_sample_echo   <= r_cur_smp;
            o_sample_valid  <= r_cur_vld;
            o_window_min    <= r_pend_acc.mn;
            o_window_max    <= r_pend_acc.mx;
            o_window_empty  <= r_pend_acc.empty;
            o_invalid_total <= r_inv_cnt;
        end
    end

    // chain head: new sample and a fresh token for an empty window
    assign w_smp[0]       = i_sample;
    assign w_vld[0]       = w_in_vld;
    assign w_acc[0].tok   = r_inject;
    assign w_acc[0].mn    = swmm_pkg::LIMIT_150;
    assign w_acc[0].mx    = '0;
    assign w_acc[0].empty = 1'b1;
    assign w_toks[0]      = r_inject;

    // cell chain, position k holds the sample of age k
    for (genvar k = 0; k < WMAX; k++) begin : g_cell
        assign w_in_win[k] = (k == 0) || (32'(k) < 32'(r_win_size));
        assign w_toks[k+1] = w_acc[k+1].tok;

        swmm_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (w_accept),
            .i_smp    (w_smp[k]),
            .i_vld    (w_vld[k]),
            .i_in_win (w_in_win[k]),
            .i_acc    (w_acc[k]),
            .o_smp    (w_smp[k+1]),
            .o_vld    (w_vld[k+1]),
            .o_acc    (w_acc[k+1])
        );
    end

    // assertions
    `SWMM_ASSERT(a_one_token, i_clk, i_rst_n, $onehot0(w_toks))
    `SWMM_ASSERT_IMPL(a_accept_chain_idle, i_clk, i_rst_n, w_accept, w_toks == '0)
    `SWMM_ASSERT_IMPL(a_token_busy, i_clk, i_rst_n, w_toks != '0, r_busy)
    `SWMM_ASSERT_IMPL(a_exit_pend_free, i_clk, i_rst_n, w_exit, !r_pend_full)
    `SWMM_ASSERT_IMPL(a_pend_busy, i_clk, i_rst_n, r_pend_full, r_busy)

endmodule

// ----- sim/sliding_window_min_max_top_tb.sv -----
// ----------------------------------------------------------------------------
// sliding_window_min_max_top_tb
// Self-checking bench for the sliding window min/max block. Samples are sent
// over the stall handshake, a local copy of the sample ring predicts each
// result, and every accepted result is compared field by field in order.
// Window sizes cover zero, one, the full ring and saturating values, changed
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module sliding_window_min_max_top_tb;

    localparam int LATENCY     = 35;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int MAX_REPORTS = 10;

    // one expected or observed result transaction
    typedef struct packed {
        logic [swmm_pkg::CNT_W-1:0] sample_index;
        logic [swmm_pkg::SMP_W-1:0] sample_echo;
        logic                       sample_valid;
        logic [swmm_pkg::SMP_W-1:0] window_min;
        logic [swmm_pkg::SMP_W-1:0] window_max;
        logic                       window_empty;
        logic [swmm_pkg::CNT_W-1:0] invalid_total;
    } t_window_result;

    // block inputs, known from time zero
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic [swmm_pkg::SMP_W-1:0] i_sample = '0;
    logic                       i_out_stall = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic [swmm_pkg::CFG_W-1:0] i_cfg_data = '0;

    // block outputs
    logic                       o_in_stall;
    logic                       o_out_valid;
    logic [swmm_pkg::CNT_W-1:0] o_sample_index;
    logic [swmm_pkg::SMP_W-1:0] o_sample_echo;
    logic                       o_sample_valid;
    logic [swmm_pkg::SMP_W-1:0] o_window_min;
    logic [swmm_pkg::SMP_W-1:0] o_window_max;
    logic                       o_window_empty;
    logic [swmm_pkg::CNT_W-1:0] o_invalid_total;
    logic                       o_cfg_ready;

    // local copy of the block state
    logic [swmm_pkg::SMP_W-1:0] ring_sample [swmm_pkg::WINDOW_MAX];
    logic                       ring_ok [swmm_pkg::WINDOW_MAX];
    int unsigned                ring_wr = 0;
    logic [swmm_pkg::CNT_W-1:0] seen_count = '0;
    logic [swmm_pkg::CNT_W-1:0] bad_count = '0;
    logic [swmm_pkg::CFG_W-1:0] win_size = swmm_pkg::WIN_SIZE_RST;

    t_window_result   expected_windows[$];
    t_window_result   want_result;
    t_window_result   got_result;

    // idling and hold-off control
    int unsigned      src_idle_pct = 0;
    int unsigned      dst_idle_pct = 0;
    logic             hold_armed = 1'b0;
    int unsigned      hold_left = 0;
    int unsigned      bad_run_left = 0;

    // bookkeeping
    int unsigned      cycle_count = 0;
    int unsigned      mismatches = 0;
    int unsigned      samples_sent = 0;
    int unsigned      results_checked = 0;
    int unsigned      size_writes = 0;

    sliding_window_min_max_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_sample        (i_sample),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_sample_index  (o_sample_index),
        .o_sample_echo   (o_sample_echo),
        .o_sample_valid  (o_sample_valid),
        .o_window_min    (o_window_min),
        .o_window_max    (o_window_max),
        .o_window_empty  (o_window_empty),
        .o_invalid_total (o_invalid_total),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_windows.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ring starts with nothing valid
    initial begin
        for (int i = 0; i < swmm_pkg::WINDOW_MAX; i++) begin
            ring_sample[i] = '0;
            ring_ok[i] = 1'b0;
        end
    end

    // push one sample into the ring and compute the window it closes
    function automatic t_window_result advance_window(
        input logic [swmm_pkg::SMP_W-1:0] smp);
        t_window_result r;
        int unsigned    span;
        int unsigned    slot;
        r.sample_echo  = smp;
        r.sample_valid = (smp < swmm_pkg::LIMIT_150);
        ring_sample[ring_wr] = smp;
        ring_ok[ring_wr]     = r.sample_valid;
        seen_count = seen_count + 1'b1;
        if (!r.sample_valid && bad_count != swmm_pkg::CNT_MAX)
            bad_count = bad_count + 1'b1;
        r.sample_index  = seen_count;
        r.invalid_total = bad_count;
        // zero acts as one, oversize clamps to the ring depth
        if (win_size == 0)
            span = 1;
        else if (win_size > swmm_pkg::WINDOW_MAX)
            span = swmm_pkg::WINDOW_MAX;
        else
            span = 32'(win_size);
        r.window_min   = swmm_pkg::LIMIT_150;
        r.window_max   = '0;
        r.window_empty = 1'b1;
        for (int k = 0; k < span; k++) begin
            slot = (ring_wr + swmm_pkg::WINDOW_MAX - k) % swmm_pkg::WINDOW_MAX;
            if (ring_ok[slot]) begin
                if (ring_sample[slot] < r.window_min) r.window_min = ring_sample[slot];
                if (ring_sample[slot] > r.window_max) r.window_max = ring_sample[slot];
                r.window_empty = 1'b0;
            end
        end
        ring_wr = (ring_wr + 1) % swmm_pkg::WINDOW_MAX;
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got, input logic [15:0] idx);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch on sample %0d: %s expected %0d, got %0d",
                         idx, fname, want, got);
        end
    endtask

    // result checking
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_result = '{o_sample_index, o_sample_echo, o_sample_valid,
                           o_window_min, o_window_max, o_window_empty,
                           o_invalid_total};
            if (expected_windows.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result transaction, sample index %0d",
                             o_sample_index);
            end else begin
                want_result = expected_windows.pop_front();
                results_checked++;
                check_field("sample_index", want_result.sample_index,
                            got_result.sample_index, want_result.sample_index);
                check_field("sample_echo", want_result.sample_echo,
                            got_result.sample_echo, want_result.sample_index);
                check_field("sample_valid", 16'(want_result.sample_valid),
                            16'(got_result.sample_valid), want_result.sample_index);
                check_field("window_min", want_result.window_min,
                            got_result.window_min, want_result.sample_index);
                check_field("window_max", want_result.window_max,
                            got_result.window_max, want_result.sample_index);
                check_field("window_empty", 16'(want_result.window_empty),
                            16'(got_result.window_empty), want_result.sample_index);
                check_field("invalid_total", want_result.invalid_total,
                            got_result.invalid_total, want_result.sample_index);
            end
        end
    end

    // receiver stall pattern and long hold-off
    always @(posedge i_clk) begin
        if (hold_armed) begin
            hold_left  = HOLD_CYCLES;
            hold_armed = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < dst_idle_pct);
        end
    end

    // send one sample transaction, leaving valid high on return
    task automatic send_sample(input logic [swmm_pkg::SMP_W-1:0] smp);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= smp;
        do @(posedge i_clk); while (o_in_stall);
        expected_windows.push_back(advance_window(smp));
        samples_sent++;
    endtask

    task automatic end_burst();
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_all_results();
        while (expected_windows.size() != 0)
            @(posedge i_clk);
    endtask

    // window size write, only while the block is idle
    task automatic write_window_size(input logic [swmm_pkg::CFG_W-1:0] value);
        wait_all_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        win_size = value;
        size_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int unsigned src_pct, input int unsigned dst_pct);
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
    endtask

    // random sample mix: mostly valid, runs of invalid readings to empty windows
    function automatic logic [swmm_pkg::SMP_W-1:0] random_sample();
        int unsigned pick;
        if (bad_run_left > 0) begin
            bad_run_left--;
            return swmm_pkg::SMP_W'($urandom_range(38400, 65535));
        end
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            bad_run_left = $urandom_range(1, 40);
            return swmm_pkg::SMP_W'($urandom_range(38400, 65535));
        end
        if (pick < 15) return swmm_pkg::SMP_W'($urandom_range(0, 65535));
        if (pick < 25) return swmm_pkg::SMP_W'($urandom_range(38396, 38404));
        if (pick < 30) return swmm_pkg::SMP_W'($urandom_range(0, 3));
        return swmm_pkg::SMP_W'($urandom_range(0, 38399));
    endfunction

    task automatic send_random_burst(input int unsigned count);
        for (int unsigned n = 0; n < count; n++)
            send_sample(random_sample());
        end_burst();
    endtask

    // reset value of the window is one: each result sees only its own sample
    task automatic test_reset_window();
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'd38399);
        send_sample(16'd38400);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        send_sample(16'd1);
        end_burst();
    endtask

    // a size of zero behaves as one
    task automatic test_size_zero();
        write_window_size(6'd0);
        send_sample(16'd200);
        send_sample(16'd38400);
        send_sample(16'd100);
        send_sample(16'd38401);
        end_burst();
    endtask

    // oversize clamps to the full ring, which already holds earlier samples
    task automatic test_size_saturate();
        write_window_size(6'd63);
        send_sample(16'd38399);
        send_sample(16'd38400);
        send_sample(16'd0);
        send_sample(16'hFFFF);
        send_sample(16'd12345);
        send_sample(16'd38398);
        send_sample(16'd38402);
        send_sample(16'd7);
        end_burst();
    endtask

    task automatic test_sender_light_idle();
        write_window_size(6'd32);
        set_idling(17, 87);
        send_random_burst(500);
    endtask

    task automatic test_receiver_light_idle();
        write_window_size(6'd9);
        set_idling(87, 17);
        send_random_burst(500);
    endtask

    task automatic test_no_idle();
        set_idling(0, 0);
        write_window_size(6'd20);
        send_random_burst(250);
        write_window_size(6'd2);
        send_random_burst(250);
    endtask

    // receiver holds off long enough that the block fills and stalls its input
    task automatic test_backpressure();
        write_window_size(6'd33);
        set_idling(0, 0);
        @(negedge i_clk);
        hold_armed = 1'b1;
        @(posedge i_clk);
        send_random_burst(150);
    endtask

    // sender pauses until every outstanding result has come back
    task automatic test_sender_pause();
        write_window_size(6'd17);
        set_idling(0, 0);
        for (int b = 0; b < 10; b++) begin
            send_random_burst(10);
            wait_all_results();
        end
        write_window_size(6'd1);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_window();
        test_size_zero();
        test_size_saturate();
        test_sender_light_idle();
        test_receiver_light_idle();
        test_no_idle();
        test_backpressure();
        test_sender_pause();

        wait_all_results();
        repeat (2 * LATENCY) @(posedge i_clk);

        $display("%0d samples sent, %0d results checked, %0d invalid readings",
                 samples_sent, results_checked, bad_count);
        $display("%0d window size writes including 0, 1, 32 and oversize values",
                 size_writes);
        if (mismatches == 0 && expected_windows.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_windows.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- sliding_window_min_max_top.f -----
+incdir+src
src/swmm_pkg.sv
src/swmm_cell.sv
src/sliding_window_min_max_top.sv
sim/sliding_window_min_max_top_tb.sv
